FILE: sv/bmp_pkg.sv
// Shared widths, types and datapath command codes for the binomial residue block.
`timescale 1ns / 1ps

package bmp_pkg;

  localparam int N_WIDTH   = 16;
  localparam int MOD_WIDTH = 31;
  localparam int OP_WIDTH  = (N_WIDTH > MOD_WIDTH) ? N_WIDTH : MOD_WIDTH;
  localparam int CNT_WIDTH = $clog2(OP_WIDTH + 1);

  typedef logic [N_WIDTH-1:0]   count_t;
  typedef logic [MOD_WIDTH-1:0] residue_t;
  typedef logic [OP_WIDTH-1:0]  operand_t;

  localparam residue_t MODULUS_RESET = MOD_WIDTH'(1000000007);

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_FACT_START,
    CMD_FACT_WB,
    CMD_EXP_INIT,
    CMD_ACC_START,
    CMD_ACC_WB,
    CMD_SQ_START,
    CMD_SQ_WB,
    CMD_RES_START,
    CMD_RES_WB,
    CMD_OUT_LOAD
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic special;
    logic i_last;
    logic exp_zero;
    logic exp_lsb;
    logic mul_done;
    logic second;
  } dp_status_t;

endpackage

FILE: sv/bmp_if.sv
// Valid/ready channel interfaces for the input pair and the result residue.
`timescale 1ns / 1ps

interface bmp_in_if;
  import bmp_pkg::*;

  logic   valid;
  logic   ready;
  count_t total_count;
  count_t choose_count;

  modport source (output valid, output total_count, output choose_count, input ready);
  modport sink   (input valid, input total_count, input choose_count, output ready);
endinterface

interface bmp_out_if;
  import bmp_pkg::*;

  logic     valid;
  logic     ready;
  residue_t binomial_residue;

  modport source (output valid, output binomial_residue, input ready);
  modport sink   (input valid, input binomial_residue, output ready);
endinterface

FILE: sv/bmp_modmul.sv
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module bmp_modmul (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              short_op,
  input  bmp_pkg::residue_t mult_a,
  input  bmp_pkg::operand_t mult_b,
  input  bmp_pkg::residue_t modulus,
  output logic              done,
  output bmp_pkg::residue_t product
);
  import bmp_pkg::*;

  localparam int SUM_W = MOD_WIDTH + 2;

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_WIDTH-1:0] cnt_r;
  residue_t             acc_r;
  residue_t             a_r;
  operand_t             b_r;

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] p1;
  logic [SUM_W-1:0] p2;
  residue_t         acc_nxt;

  always_comb begin
    sum = {1'b0, acc_r, 1'b0} + (b_r[OP_WIDTH-1] ? {2'b00, a_r} : SUM_W'(0));
    p1  = {2'b00, modulus};
    p2  = {1'b0, modulus, 1'b0};
    priority if (sum >= p2) begin
      acc_nxt = MOD_WIDTH'(sum - p2);
    end else if (sum >= p1) begin
      acc_nxt = MOD_WIDTH'(sum - p1);
    end else begin
      acc_nxt = MOD_WIDTH'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_WIDTH'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= mult_a;
      if (short_op) begin
        b_r   <= mult_b << (OP_WIDTH - N_WIDTH);
        cnt_r <= CNT_WIDTH'(N_WIDTH);
      end else begin
        b_r   <= mult_b << (OP_WIDTH - MOD_WIDTH);
        cnt_r <= CNT_WIDTH'(MOD_WIDTH);
      end
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= b_r << 1;
      cnt_r <= cnt_r - CNT_WIDTH'(1);
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

FILE: sv/bmp_datapath.sv
// Datapath: modulus register, factorial and exponent registers, shared multiplier.
`timescale 1ns / 1ps

module bmp_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  bmp_pkg::residue_t   cfg_wdata,
  input  bmp_pkg::count_t     in_total_count,
  input  bmp_pkg::count_t     in_choose_count,
  input  bmp_pkg::dp_cmd_t    cmd,
  output bmp_pkg::dp_status_t status,
  output bmp_pkg::residue_t   out_residue
);
  import bmp_pkg::*;

  residue_t modulus_r;
  count_t   n_r;
  count_t   r_r;
  count_t   nr_r;
  count_t   i_r;
  residue_t res_r;
  residue_t fr_r;
  residue_t fnr_r;
  residue_t base_r;
  residue_t acc_r;
  residue_t exp_r;
  logic     special_r;
  logic     second_r;
  residue_t out_r;

  logic     mul_start;
  logic     mul_short;
  residue_t mul_a;
  operand_t mul_b;
  logic     mul_done;
  residue_t mul_product;
  logic     in_bad;

  always_comb begin
    mul_start = 1'b0;
    mul_short = 1'b0;
    mul_a     = res_r;
    mul_b     = OP_WIDTH'(acc_r);
    unique case (cmd.op)
      CMD_FACT_START: begin
        mul_start = 1'b1;
        mul_short = 1'b1;
        mul_a     = res_r;
        mul_b     = OP_WIDTH'(i_r);
      end
      CMD_ACC_START: begin
        mul_start = 1'b1;
        mul_a     = acc_r;
        mul_b     = OP_WIDTH'(base_r);
      end
      CMD_SQ_START: begin
        mul_start = 1'b1;
        mul_a     = base_r;
        mul_b     = OP_WIDTH'(base_r);
      end
      CMD_RES_START: begin
        mul_start = 1'b1;
        mul_a     = res_r;
        mul_b     = OP_WIDTH'(acc_r);
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  bmp_modmul u_modmul (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mul_start),
    .short_op (mul_short),
    .mult_a   (mul_a),
    .mult_b   (mul_b),
    .modulus  (modulus_r),
    .done     (mul_done),
    .product  (mul_product)
  );

  assign in_bad = (modulus_r < residue_t'(2)) || (in_total_count < in_choose_count);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_RESET;
      special_r <= 1'b0;
      second_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        modulus_r <= cfg_wdata;
      end
      if (cmd.op == CMD_LOAD) begin
        special_r <= in_bad || (in_choose_count == '0);
        second_r  <= 1'b0;
      end else if (cmd.op == CMD_RES_WB) begin
        second_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_LOAD: begin
        n_r   <= in_total_count;
        r_r   <= in_choose_count;
        nr_r  <= in_total_count - in_choose_count;
        i_r   <= N_WIDTH'(1);
        res_r <= in_bad ? '0 : MOD_WIDTH'(1);
        fr_r  <= MOD_WIDTH'(1);
        fnr_r <= MOD_WIDTH'(1);
      end
      CMD_FACT_WB: begin
        res_r <= mul_product;
        if (i_r == r_r) begin
          fr_r <= mul_product;
        end
        if (i_r == nr_r) begin
          fnr_r <= mul_product;
        end
        i_r <= i_r + N_WIDTH'(1);
      end
      CMD_EXP_INIT: begin
        base_r <= second_r ? fnr_r : fr_r;
        acc_r  <= MOD_WIDTH'(1);
        exp_r  <= modulus_r - MOD_WIDTH'(2);
      end
      CMD_ACC_WB: begin
        acc_r <= mul_product;
      end
      CMD_SQ_WB: begin
        base_r <= mul_product;
        exp_r  <= exp_r >> 1;
      end
      CMD_RES_WB: begin
        res_r <= mul_product;
      end
      CMD_OUT_LOAD: begin
        out_r <= res_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status.special  = special_r;
    status.i_last   = (i_r == n_r);
    status.exp_zero = (exp_r == '0);
    status.exp_lsb  = exp_r[0];
    status.mul_done = mul_done;
    status.second   = second_r;
  end

  assign out_residue = out_r;

endmodule

FILE: sv/bmp_ctrl.sv
// Controller: sequences factorial, two Fermat inversions and result transfer.
`timescale 1ns / 1ps

module bmp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output bmp_pkg::dp_cmd_t    cmd,
  input  bmp_pkg::dp_status_t status
);
  import bmp_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CHECK     = 4'd1;
  localparam logic [3:0] S_FACT_GO   = 4'd2;
  localparam logic [3:0] S_FACT_WAIT = 4'd3;
  localparam logic [3:0] S_EXP_INIT  = 4'd4;
  localparam logic [3:0] S_EXP_STEP  = 4'd5;
  localparam logic [3:0] S_ACC_WAIT  = 4'd6;
  localparam logic [3:0] S_SQ_GO     = 4'd7;
  localparam logic [3:0] S_SQ_WAIT   = 4'd8;
  localparam logic [3:0] S_RES_WAIT  = 4'd9;
  localparam logic [3:0] S_FINISH    = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = CMD_NONE;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = CMD_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.special) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.op    = CMD_FACT_START;
          state_nxt = S_FACT_WAIT;
        end
      end
      S_FACT_GO: begin
        cmd.op    = CMD_FACT_START;
        state_nxt = S_FACT_WAIT;
      end
      S_FACT_WAIT: begin
        if (status.mul_done) begin
          cmd.op    = CMD_FACT_WB;
          state_nxt = status.i_last ? S_EXP_INIT : S_FACT_GO;
        end
      end
      S_EXP_INIT: begin
        cmd.op    = CMD_EXP_INIT;
        state_nxt = S_EXP_STEP;
      end
      S_EXP_STEP: begin
        priority if (status.exp_zero) begin
          cmd.op    = CMD_RES_START;
          state_nxt = S_RES_WAIT;
        end else if (status.exp_lsb) begin
          cmd.op    = CMD_ACC_START;
          state_nxt = S_ACC_WAIT;
        end else begin
          cmd.op    = CMD_SQ_START;
          state_nxt = S_SQ_WAIT;
        end
      end
      S_ACC_WAIT: begin
        if (status.mul_done) begin
          cmd.op    = CMD_ACC_WB;
          state_nxt = S_SQ_GO;
        end
      end
      S_SQ_GO: begin
        cmd.op    = CMD_SQ_START;
        state_nxt = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (status.mul_done) begin
          cmd.op    = CMD_SQ_WB;
          state_nxt = S_EXP_STEP;
        end
      end
      S_RES_WAIT: begin
        if (status.mul_done) begin
          cmd.op    = CMD_RES_WB;
          state_nxt = status.second ? S_FINISH : S_EXP_INIT;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = CMD_OUT_LOAD;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: sv/binomial_mod_prime_top.sv
// Top level of the binomial coefficient modulo prime block.
// Usage:
//   in_ch carries total_count (n) and choose_count (r); one transfer starts one item.
//   out_ch returns binomial_residue = C(n,r) mod p, exactly one result per item.
//   cfg_we/cfg_wdata write the modulus p; write only while the block is idle.
// Sequencing:
//   One item at a time. Items with r > n, r = 0 or p < 2 go straight to the result.
//   Otherwise the running factorial takes n steps of the bit-serial modular
//   multiplier (16 multiplier bits each), and the two inversions by
//   exponentiation to p-2 take up to 31 squarings and up to 31 products
//   each (31 multiplier bits each). The next item is taken once the result
//   sits in the output register.
// Reset:
//   rst_n low clears the controller, drops out_ch.valid and loads p = 1000000007.
// Stall:
//   A result holds on out_ch while ready is low; one further item may be taken
//   and computed, and it waits before its own transfer until the slot frees.
`timescale 1ns / 1ps

module binomial_mod_prime_top (
  input  logic              clk,
  input  logic              rst_n,
  bmp_in_if.sink            in_ch,
  bmp_out_if.source         out_ch,
  input  logic              cfg_we,
  input  bmp_pkg::residue_t cfg_wdata
);
  import bmp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  bmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  bmp_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_total_count  (in_ch.total_count),
    .in_choose_count (in_ch.choose_count),
    .cmd             (cmd),
    .status          (status),
    .out_residue     (out_ch.binomial_residue)
  );

endmodule

FILE: sv/bmp_checker.sv
// Port-level checker for the binomial residue block and its bind.
`timescale 1ns / 1ps

module bmp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input bmp_pkg::residue_t binomial_residue
);
  import bmp_pkg::*;

  a_reset_drops_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while an item is in work");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> binomial_residue != {MOD_WIDTH{1'b1}})
    else $error("residue out of range");

endmodule

bind binomial_mod_prime_top bmp_checker u_bmp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .binomial_residue (out_ch.binomial_residue)
);

FILE: test/tb.sv
// Testbench for binomial_mod_prime_top: directed table and random pairs against a predictor.
`timescale 1ns / 1ps

module tb;
  import bmp_pkg::*;

  localparam int  CYCLE_LIMIT = 10_000_000;
  localparam int  LONG_HOLD   = 20000;
  localparam int  PHASES      = 5;
  localparam int  PER_PHASE   = 16;

  typedef enum logic {STEP_ITEM, STEP_MODULUS} step_kind_t;

  typedef struct {
    step_kind_t kind;
    count_t     n;
    count_t     r;
    residue_t   value;
    bit         known;
  } step_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  residue_t cfg_wdata;

  bmp_in_if  in_ch ();
  bmp_out_if out_ch ();

  residue_t residues_due[$];
  residue_t modulus_now;
  step_t    directed_steps[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  bit       quiet_run = 1'b0;
  bit       hold_req = 1'b0;

  binomial_mod_prime_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned mod_power(longint unsigned base, longint unsigned expo,
                                                longint unsigned m);
    longint unsigned acc;
    longint unsigned b;
    acc = 1;
    b = base % m;
    while (expo > 0) begin
      if (expo[0]) acc = (acc * b) % m;
      expo = expo >> 1;
      b = (b * b) % m;
    end
    return acc;
  endfunction

  function automatic residue_t binomial_residue_of(count_t n, count_t r, residue_t p);
    longint unsigned m;
    longint unsigned prod;
    longint unsigned fr;
    longint unsigned fnr;
    longint unsigned res;
    int unsigned     i;
    int unsigned     nr;
    m = p;
    if (m < 2) return '0;
    if (n < r) return '0;
    if (r == 0) return residue_t'(1);
    nr = n - r;
    prod = 1;
    fr = 1;
    fnr = 1;
    for (i = 1; i <= n; i++) begin
      prod = (prod * i) % m;
      if (i == r) fr = prod;
      if (i == nr) fnr = prod;
    end
    res = (prod * mod_power(fr, m - 2, m)) % m;
    res = (res * mod_power(fnr, m - 2, m)) % m;
    return residue_t'(res);
  endfunction

  task automatic offer_pair(input count_t n, input count_t r, input bit known,
                            input residue_t value);
    if (!quiet_run && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.total_count  <= n;
    in_ch.choose_count <= r;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    residues_due.push_back(known ? value : binomial_residue_of(n, r, modulus_now));
  endtask

  task automatic set_modulus(input residue_t value);
    in_ch.valid <= 1'b0;
    while (residues_due.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    modulus_now = value;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL binomial_mod_prime_top");
      $finish;
    end
  end

  always @(posedge clk) begin : check_results
    residue_t expected;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (residues_due.size() == 0) begin
        $error("binomial_residue: expected none, got %0d", out_ch.binomial_residue);
        mismatch_count++;
      end else begin
        expected = residues_due.pop_front();
        if (out_ch.binomial_residue !== expected) begin
          $error("binomial_residue: expected %0d, got %0d", expected, out_ch.binomial_residue);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet_run && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int     phase;
    int     idx;
    int     kind;
    count_t n;
    count_t r;

    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.total_count  <= '0;
    in_ch.choose_count <= '0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    modulus_now = MODULUS_RESET;

    directed_steps.push_back('{STEP_ITEM, 16'd0, 16'd0, 31'd1, 1'b1});
    directed_steps.push_back('{STEP_ITEM, 16'd65535, 16'd0, 31'd1, 1'b1});
    directed_steps.push_back('{STEP_ITEM, 16'd0, 16'd65535, 31'd0, 1'b1});
    directed_steps.push_back('{STEP_ITEM, 16'd7, 16'd8, 31'd0, 1'b1});
    directed_steps.push_back('{STEP_ITEM, 16'd1, 16'd1, 31'd1, 1'b1});
    directed_steps.push_back('{STEP_ITEM, 16'd5, 16'd2, 31'd10, 1'b1});
    directed_steps.push_back('{STEP_ITEM, 16'd10, 16'd3, 31'd120, 1'b1});
    directed_steps.push_back('{STEP_ITEM, 16'd30, 16'd15, 31'd0, 1'b0});
    directed_steps.push_back('{STEP_ITEM, 16'd600, 16'd17, 31'd0, 1'b0});
    directed_steps.push_back('{STEP_MODULUS, 16'd0, 16'd0, 31'd13, 1'b0});
    directed_steps.push_back('{STEP_ITEM, 16'd13, 16'd1, 31'd0, 1'b1});
    directed_steps.push_back('{STEP_ITEM, 16'd20, 16'd7, 31'd0, 1'b0});
    directed_steps.push_back('{STEP_ITEM, 16'd12, 16'd5, 31'd0, 1'b0});
    directed_steps.push_back('{STEP_MODULUS, 16'd0, 16'd0, 31'd2, 1'b0});
    directed_steps.push_back('{STEP_ITEM, 16'd1, 16'd1, 31'd0, 1'b0});
    directed_steps.push_back('{STEP_ITEM, 16'd3, 16'd1, 31'd0, 1'b0});
    directed_steps.push_back('{STEP_MODULUS, 16'd0, 16'd0, 31'd0, 1'b0});
    directed_steps.push_back('{STEP_ITEM, 16'd5, 16'd2, 31'd0, 1'b1});
    directed_steps.push_back('{STEP_MODULUS, 16'd0, 16'd0, 31'd1, 1'b0});
    directed_steps.push_back('{STEP_ITEM, 16'd9, 16'd4, 31'd0, 1'b1});
    directed_steps.push_back('{STEP_MODULUS, 16'd0, 16'd0, 31'h7fffffff, 1'b0});
    directed_steps.push_back('{STEP_ITEM, 16'd40, 16'd20, 31'd0, 1'b0});
    directed_steps.push_back('{STEP_ITEM, 16'd100, 16'd1, 31'd100, 1'b1});
    directed_steps.push_back('{STEP_MODULUS, 16'd0, 16'd0, 31'd15, 1'b0});
    directed_steps.push_back('{STEP_ITEM, 16'd6, 16'd3, 31'd0, 1'b0});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_MODULUS) begin
        set_modulus(directed_steps[i].value);
      end else begin
        offer_pair(directed_steps[i].n, directed_steps[i].r, directed_steps[i].known,
                   directed_steps[i].value);
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: set_modulus(MODULUS_RESET);
        1: set_modulus('1);
        2: set_modulus(residue_t'($urandom_range(2, 60)));
        3: set_modulus(residue_t'($urandom_range(2, 32'h7fffffff)));
        default: set_modulus(residue_t'(998244353));
      endcase
      if (phase == 0) hold_req = 1'b1;
      if (phase == PHASES - 1) quiet_run = 1'b1;
      for (idx = 0; idx < PER_PHASE; idx++) begin
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
          n = count_t'($urandom_range(1, 120));
          r = count_t'($urandom_range(1, n));
        end else if (kind == 4) begin
          n = count_t'($urandom_range(121, 1500));
          r = count_t'($urandom_range(0, n));
        end else if (kind < 7) begin
          n = count_t'($urandom);
          r = '0;
        end else if (kind < 9) begin
          r = count_t'($urandom_range(1, 65535));
          n = count_t'($urandom_range(0, r - 1));
        end else begin
          n = count_t'($urandom_range(0, 40));
          r = count_t'($urandom_range(0, n));
        end
        offer_pair(n, r, 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (residues_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS binomial_mod_prime_top");
    end else begin
      $display("FAIL binomial_mod_prime_top");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/bmp_pkg.sv
sv/bmp_if.sv
sv/bmp_modmul.sv
sv/bmp_datapath.sv
sv/bmp_ctrl.sv
sv/binomial_mod_prime_top.sv
sv/bmp_checker.sv
test/tb.sv
